// File: src/ndefp_pkg.sv
// ----------------------------------------------------------------------------
// ndefp_pkg
// Shared types and codes for the NDEF record stream parser.
// ----------------------------------------------------------------------------
package ndefp_pkg;

   // Parse phase codes. These double as the field kind of a byte.
   localparam logic [2:0] PH_ATTR    = 3'd0;
   localparam logic [2:0] PH_TLEN    = 3'd1;
   localparam logic [2:0] PH_PLEN    = 3'd2;
   localparam logic [2:0] PH_IDLEN   = 3'd3;
   localparam logic [2:0] PH_TYPE    = 3'd4;
   localparam logic [2:0] PH_ID      = 3'd5;
   localparam logic [2:0] PH_PAYLOAD = 3'd6;
   localparam logic [2:0] PH_DONE    = 3'd7;

   // Field kind for bytes past the end of the record
   localparam logic [2:0] KIND_TRAILING = 3'd7;

   // Record status codes
   localparam logic [1:0] STAT_IN_PROGRESS = 2'd0;
   localparam logic [1:0] STAT_OK          = 2'd1;
   localparam logic [1:0] STAT_TRUNCATED   = 2'd2;
   localparam logic [1:0] STAT_BAD_HEADER  = 2'd3;

   // Attribute flag positions: short record, ID length present
   localparam int ATTR_SR_BIT = 4;
   localparam int ATTR_IL_BIT = 3;

   // Long-form payload lengths must reach this value
   localparam int LONG_FORM_MIN = 256;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 32;
   localparam int REC_LEN_W = 33;

   // One input word
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_item_type;

   // One result word
   typedef struct packed {
      logic [BYTE_W-1:0]    byte_value;
      logic [2:0]           field_kind;
      logic [1:0]           record_status;
      logic [BYTE_W-1:0]    attribute;
      logic [BYTE_W-1:0]    type_length;
      logic [BYTE_W-1:0]    id_length;
      logic [LEN_W-1:0]     payload_length;
      logic [REC_LEN_W-1:0] record_length;
   } rsp_item_type;

endpackage

// File: src/ndefp_ifs.sv
// ----------------------------------------------------------------------------
// ndefp_ifs
// Valid/ready channel interfaces for the request and response streams.
// ----------------------------------------------------------------------------
interface ndefp_req_if;
   logic                    valid;
   logic                    ready;
   ndefp_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ndefp_rsp_if;
   logic                    valid;
   logic                    ready;
   ndefp_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/ndefp_field_tracker.sv
// ----------------------------------------------------------------------------
// ndefp_field_tracker
// Record header state and per-byte phase step. Computes the result word for
// the byte at its input and commits the new state when step is high.
// ----------------------------------------------------------------------------
module ndefp_field_tracker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  ndefp_pkg::req_item_type item,
   output ndefp_pkg::rsp_item_type result
);
   import ndefp_pkg::*;

   typedef struct packed {
      logic [2:0]       phase;
      logic [LEN_W-1:0] remaining;
   } entry_type;

   // Skip empty fields starting at the type field
   function automatic entry_type enter_type(input logic [BYTE_W-1:0] tlen,
                                            input logic [BYTE_W-1:0] idlen,
                                            input logic [LEN_W-1:0]  plen);
      entry_type e;
      if (tlen != '0) begin
         e.phase     = PH_TYPE;
         e.remaining = {{(LEN_W-BYTE_W){1'b0}}, tlen};
      end else if (idlen != '0) begin
         e.phase     = PH_ID;
         e.remaining = {{(LEN_W-BYTE_W){1'b0}}, idlen};
      end else if (plen != '0) begin
         e.phase     = PH_PAYLOAD;
         e.remaining = plen;
      end else begin
         e.phase     = PH_DONE;
         e.remaining = '0;
      end
      return e;
   endfunction

   logic [2:0]           phase_ff,    phase_in;
   logic [BYTE_W-1:0]    attr_ff,     attr_in;
   logic [BYTE_W-1:0]    tlen_ff,     tlen_in;
   logic [BYTE_W-1:0]    idlen_ff,    idlen_in;
   logic [LEN_W-1:0]     plen_ff,     plen_in;
   logic [LEN_W-1:0]     remain_ff,   remain_in;
   logic [REC_LEN_W-1:0] consumed_ff, consumed_in;

   entry_type            entry;
   logic [LEN_W-1:0]     remain_dec;
   logic                 field_end;
   logic                 bad_header;
   logic                 rec_done;

   assign remain_dec = remain_ff - LEN_W'(1);
   assign field_end  = (remain_ff == LEN_W'(1));

   // Phase step for one byte
   always_comb begin
      phase_in    = phase_ff;
      attr_in     = attr_ff;
      tlen_in     = tlen_ff;
      idlen_in    = idlen_ff;
      plen_in     = plen_ff;
      remain_in   = remain_ff;
      consumed_in = consumed_ff;
      entry       = '0;

      if (phase_ff != PH_DONE) begin
         consumed_in = consumed_ff + REC_LEN_W'(1);
         unique case (phase_ff)
            PH_ATTR: begin
               attr_in  = item.data_byte;
               phase_in = PH_TLEN;
            end
            PH_TLEN: begin
               tlen_in   = item.data_byte;
               plen_in   = '0;
               remain_in = attr_ff[ATTR_SR_BIT] ? LEN_W'(1) : LEN_W'(4);
               phase_in  = PH_PLEN;
            end
            PH_PLEN: begin
               plen_in   = {plen_ff[LEN_W-BYTE_W-1:0], item.data_byte};
               remain_in = remain_dec;
               if (field_end) begin
                  if (attr_ff[ATTR_IL_BIT]) begin
                     phase_in = PH_IDLEN;
                  end else begin
                     entry     = enter_type(tlen_ff, idlen_ff, plen_in);
                     phase_in  = entry.phase;
                     remain_in = entry.remaining;
                  end
               end
            end
            PH_IDLEN: begin
               idlen_in  = item.data_byte;
               entry     = enter_type(tlen_ff, item.data_byte, plen_ff);
               phase_in  = entry.phase;
               remain_in = entry.remaining;
            end
            PH_TYPE: begin
               remain_in = remain_dec;
               if (field_end) begin
                  entry     = enter_type('0, idlen_ff, plen_ff);
                  phase_in  = entry.phase;
                  remain_in = entry.remaining;
               end
            end
            PH_ID: begin
               remain_in = remain_dec;
               if (field_end) begin
                  entry     = enter_type('0, '0, plen_ff);
                  phase_in  = entry.phase;
                  remain_in = entry.remaining;
               end
            end
            default: begin
               // payload bytes
               remain_in = remain_dec;
               if (field_end) begin
                  phase_in = PH_DONE;
               end
            end
         endcase
      end
   end

   // Header size rule, checked on the completing byte
   assign bad_header = (!attr_in[ATTR_SR_BIT] && (plen_in < LEN_W'(LONG_FORM_MIN))) ||
                       (attr_in[ATTR_IL_BIT] && (idlen_in == '0));
   assign rec_done   = (phase_ff != PH_DONE) && (phase_in == PH_DONE);

   // Result word
   always_comb begin
      result.byte_value     = item.data_byte;
      result.field_kind     = (phase_ff == PH_DONE) ? KIND_TRAILING : phase_ff;
      result.attribute      = attr_in;
      result.type_length    = tlen_in;
      result.id_length      = idlen_in;
      result.payload_length = plen_in;
      result.record_length  = '0;
      priority if (phase_ff == PH_DONE) begin
         result.record_status = STAT_IN_PROGRESS;
      end else if (rec_done && bad_header) begin
         result.record_status = STAT_BAD_HEADER;
      end else if (rec_done) begin
         result.record_status = STAT_OK;
         result.record_length = consumed_in;
      end else if (item.last_byte) begin
         result.record_status = STAT_TRUNCATED;
      end else begin
         result.record_status = STAT_IN_PROGRESS;
      end
   end

   // State registers; a last byte restarts the parser after its result
   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         phase_ff    <= PH_ATTR;
         attr_ff     <= '0;
         tlen_ff     <= '0;
         idlen_ff    <= '0;
         plen_ff     <= '0;
         remain_ff   <= '0;
         consumed_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         attr_ff     <= attr_in;
         tlen_ff     <= tlen_in;
         idlen_ff    <= idlen_in;
         plen_ff     <= plen_in;
         remain_ff   <= remain_in;
         consumed_ff <= consumed_in;
      end
   end

   // A last byte always leaves the parser waiting for an attribute byte
   a_restart_on_last: assert property (@(posedge clock) disable iff (reset)
      (step && item.last_byte) |=> (phase_ff == PH_ATTR && consumed_ff == '0))
      else $error("parser did not restart after last byte");

endmodule

// File: src/ndef_record_stream_parser.sv
// ----------------------------------------------------------------------------
// ndef_record_stream_parser
// Tags each byte of an NDEF record with its field and reports the record's
// status on the completing byte, or TRUNCATED on a last byte that ends it early.
//
//   channel   dir  payload                              handshake
//   req_chan  in   data_byte, last_byte                 valid/ready
//   rsp_chan  out  byte_value, field_kind, status, hdr  valid/ready
//
// One word per cycle sustained while rsp_chan is ready; an accepted word goes
// from the input register to the output register. The rate is set by the
// combinational phase step in the field tracker, between the two registers.
// Synchronous reset clears both register valids and all parse state.
// A stalled rsp holds the output register; the input register still takes
// one more word, and req_chan.ready drops only when both are full.
// ----------------------------------------------------------------------------
module ndef_record_stream_parser (
   input logic         clock,
   input logic         reset,
   ndefp_req_if.sink   req_chan,
   ndefp_rsp_if.source rsp_chan
);
   import ndefp_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;

   // Move a word from input to output register when the output is free
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= req_chan.payload;
      end
   end

   ndefp_field_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

   // Record length only reported on a good record
   a_len_only_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.record_status != STAT_OK)
         |-> (out_item_ff.record_length == '0))
      else $error("record length set without ok status");

   // Trailing bytes carry no status
   a_trailing_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.field_kind == KIND_TRAILING)
         |-> (out_item_ff.record_status == STAT_IN_PROGRESS))
      else $error("trailing byte with status");

   // An accepted word is held in the input register next cycle
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> in_valid_ff)
      else $error("accepted word lost");

   // A word moved forward shows up on the response side
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word lost");

endmodule
